>>> src/crb_pkg.sv
// Shared types, character codes and decode functions for the CIGAR boundary extractor.
package crb_pkg;

    // Field widths.
    localparam int unsigned ByteW  = 8;
    localparam int unsigned StartW = 31;
    localparam int unsigned PosW   = 32;
    localparam int unsigned LenW   = 28;
    localparam int unsigned CountW = 4;

    // Stream data widths, packed and padded to whole bytes.
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 40;

    localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
    localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

    // ASCII codes of the operation letters and the digit range.
    localparam logic [ByteW-1:0] ChDigit0 = 8'h30;
    localparam logic [ByteW-1:0] ChDigit9 = 8'h39;
    localparam logic [ByteW-1:0] ChM      = 8'h4D;
    localparam logic [ByteW-1:0] ChMLower = 8'h6D;
    localparam logic [ByteW-1:0] ChEq     = 8'h3D;
    localparam logic [ByteW-1:0] ChX      = 8'h58;
    localparam logic [ByteW-1:0] ChN      = 8'h4E;
    localparam logic [ByteW-1:0] ChD      = 8'h44;
    localparam logic [ByteW-1:0] ChI      = 8'h49;
    localparam logic [ByteW-1:0] ChS      = 8'h53;
    localparam logic [ByteW-1:0] ChH      = 8'h48;
    localparam logic [ByteW-1:0] ChP      = 8'h50;

    // Running per-read parser state.
    typedef struct packed {
        logic [PosW-1:0]   pos;
        logic [LenW-1:0]   len;
        logic [CountW-1:0] ops;
        logic [CountW-1:0] bnd;
        logic              err;
    } t_state;

    // One input item.
    typedef struct packed {
        logic [ByteW-1:0]  cigar_byte;
        logic [StartW-1:0] read_start;
        logic              first_of_read;
        logic              last_of_read;
    } t_item;

    // One result item.
    typedef struct packed {
        logic              boundary_valid;
        logic [PosW-1:0]   boundary_position;
        logic [CountW-1:0] boundary_index;
        logic              end_of_read;
        logic              malformed;
    } t_result;

    function automatic logic is_digit(input logic [ByteW-1:0] c);
        return (c >= ChDigit0) && (c <= ChDigit9);
    endfunction

    function automatic logic moves_ref(input logic [ByteW-1:0] c);
        return (c == ChM) || (c == ChMLower) || (c == ChEq) ||
               (c == ChX) || (c == ChN) || (c == ChD);
    endfunction

    function automatic logic is_op(input logic [ByteW-1:0] c);
        return moves_ref(c) || (c == ChI) || (c == ChS) || (c == ChH) || (c == ChP);
    endfunction

endpackage

>>> src/crb_step.sv
// Next-state and result logic for one CIGAR byte.
module crb_step #(
    parameter int unsigned MAX_OPS = 10
) (
    input  crb_pkg::t_state  i_state,
    input  crb_pkg::t_item   i_item,
    output crb_pkg::t_state  o_state,
    output crb_pkg::t_result o_result,
    output logic             o_emit
);

    localparam logic [crb_pkg::CountW-1:0] OpsLimit = crb_pkg::CountW'(MAX_OPS);

    crb_pkg::t_state             eff;
    crb_pkg::t_state             nxt;
    logic [crb_pkg::PosW-1:0]    len_wide;
    logic [crb_pkg::PosW-1:0]    len_times_ten;
    logic [crb_pkg::PosW:0]      pos_sum;
    logic                        boundary;

    // A first byte restarts the read from its start position.
    always_comb begin
        if (i_item.first_of_read) begin
            eff     = '0;
            eff.pos = {1'b0, i_item.read_start};
        end else begin
            eff = i_state;
        end
    end

    // Decimal accumulate and saturating reference add.
    assign len_wide      = {{(crb_pkg::PosW - crb_pkg::LenW){1'b0}}, eff.len};
    assign len_times_ten = (len_wide << 3) + (len_wide << 1)
                         + {{(crb_pkg::PosW - 4){1'b0}}, i_item.cigar_byte[3:0]};
    assign pos_sum       = {1'b0, eff.pos} + {1'b0, len_wide};

    // Byte classification and state update.
    always_comb begin
        nxt      = eff;
        boundary = 1'b0;
        if (crb_pkg::is_digit(i_item.cigar_byte)) begin
            if (len_times_ten[crb_pkg::PosW-1:crb_pkg::LenW] != '0) begin
                nxt.len = crb_pkg::LenMax;
                nxt.err = 1'b1;
            end else begin
                nxt.len = len_times_ten[crb_pkg::LenW-1:0];
            end
        end else if (crb_pkg::is_op(i_item.cigar_byte)) begin
            if (eff.ops >= OpsLimit) begin
                nxt.err = 1'b1;
            end else begin
                nxt.ops = eff.ops + crb_pkg::CountW'(1);
                if (crb_pkg::moves_ref(i_item.cigar_byte)) begin
                    nxt.pos  = pos_sum[crb_pkg::PosW] ? crb_pkg::PosMax
                                                      : pos_sum[crb_pkg::PosW-1:0];
                    nxt.bnd  = eff.bnd + crb_pkg::CountW'(1);
                    boundary = 1'b1;
                end
            end
            nxt.len = '0;
        end else begin
            // Unknown byte: flag it and keep any pending length.
            nxt.err = 1'b1;
        end
    end

    // The result reflects the state after the byte; a dangling length is dropped at the end.
    always_comb begin
        o_state = nxt;
        if (i_item.last_of_read) begin
            o_state.len = '0;
        end
        o_result.boundary_valid    = boundary;
        o_result.boundary_position = nxt.pos;
        o_result.boundary_index    = nxt.bnd;
        o_result.end_of_read       = i_item.last_of_read;
        o_result.malformed         = nxt.err;
        o_emit                     = boundary || i_item.last_of_read;
    end

endmodule

>>> src/cigar_reference_boundaries.sv
// Top level of the CIGAR reference-boundary extractor: input register, parser state, result register.
// The block takes one CIGAR character per transfer and can accept a new character every cycle.
// Each character is held in the input register; its length accumulate, saturating
// reference add and result selection then complete combinationally into the parser state
// and the result register, from which a boundary is presented on the output. The input side
// stalls only while the result register is full and not being taken and the waiting
// character would produce a result.
module cigar_reference_boundaries #(
    parameter int unsigned MAX_OPS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [7:0] cigar_byte, [38:8] read_start, [39] zero pad
    input  logic [crb_pkg::InDataW-1:0]  i_s_tdata,
    // [0] first_of_read
    input  logic                         i_s_tuser,
    // last_of_read
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [31:0] boundary_position, [35:32] boundary_index, [39:36] zero pad
    output logic [crb_pkg::OutDataW-1:0] o_m_tdata,
    // [0] boundary_valid, [1] malformed
    output logic [1:0]                   o_m_tuser,
    // end_of_read
    output logic                         o_m_tlast
);

    logic             r_in_valid;
    crb_pkg::t_item   r_item;
    crb_pkg::t_state  r_state;
    crb_pkg::t_state  n_state;
    logic             r_out_valid;
    crb_pkg::t_result r_result;
    crb_pkg::t_result n_result;
    logic             emit;
    logic             advance;

    crb_step #(
        .MAX_OPS (MAX_OPS)
    ) u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result),
        .o_emit   (emit)
    );

    // The held character moves on when its result, if any, has room.
    assign advance    = r_in_valid && (!emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.cigar_byte    <= i_s_tdata[crb_pkg::ByteW-1:0];
            r_item.read_start    <= i_s_tdata[crb_pkg::ByteW +: crb_pkg::StartW];
            r_item.first_of_read <= i_s_tuser;
            r_item.last_of_read  <= i_s_tlast;
        end
        if (advance && emit) begin
            r_result <= n_result;
        end
    end

    // Output stream.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(crb_pkg::OutDataW - crb_pkg::PosW - crb_pkg::CountW){1'b0}},
                         r_result.boundary_index, r_result.boundary_position};
    assign o_m_tuser  = {r_result.malformed, r_result.boundary_valid};
    assign o_m_tlast  = r_result.end_of_read;

    // A result that does not end the read must carry a boundary.
    a_result_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> o_m_tuser[0])
        else $error("result without boundary or end of read");

    // Boundary numbering starts at one.
    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[35:32] != '0))
        else $error("boundary carries index zero");

    // The counted operations never pass the limit.
    a_ops_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.ops <= crb_pkg::CountW'(MAX_OPS))
        else $error("operation count beyond limit");

    // Every boundary belongs to a counted operation.
    a_bnd_le_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bnd <= r_state.ops)
        else $error("more boundaries than operations");

endmodule
